### rtl/core/sorted_timer_queue_assert.svh
// ---------------------------------------------------------------------------
// sorted_timer_queue assertion macros
// Clocked, reset-qualified assertion wrappers used by the timer queue RTL.
// ---------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define STQ_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence
`define STQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/stq_pkg.sv
// ---------------------------------------------------------------------------
// stq_pkg
// Shared types, operation and status codes for the sorted timer queue.
// ---------------------------------------------------------------------------
package stq_pkg;

  localparam int NUM_TIMERS_DEF   = 16;
  localparam int TIMEOUT_BITS_DEF = 32;
  localparam int TIME_W           = 48;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Operation codes
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_CANCEL   = 3'd1;
  localparam logic [2:0] OP_TICK     = 3'd2;
  localparam logic [2:0] OP_QUERY    = 3'd3;
  localparam logic [2:0] OP_SHUTDOWN = 3'd4;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_RUNNING = 2'd1;
  localparam logic [1:0] STS_CLOSED  = 2'd2;
  localparam logic [1:0] STS_EMPTY   = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  timer_id;
    logic [31:0] timeout_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [3:0]  fired_timer;
    logic [31:0] time_to_next;
    logic        last;
  } out_item_t;

  // Request and result of the shared add / subtract unit
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic              carry;
    logic [TIME_W-1:0] sum;
  } alu_res_t;

endpackage

### rtl/core/stq_alu.sv
// ---------------------------------------------------------------------------
// stq_alu
// Shared 48-bit adder / subtractor: deadline sums, tick increment and
// deadline compares all go through this one unit.
// ---------------------------------------------------------------------------
module stq_alu
  import stq_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  logic [TIME_W-1:0] b_eff;
  logic [TIME_W:0]   total;

  // Invert b and add one for subtract; carry set means a >= b on subtract
  assign b_eff = req.b ^ {TIME_W{req.sub}};
  assign total = {1'b0, req.a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, req.sub};
  assign res.carry = total[TIME_W];
  assign res.sum   = total[TIME_W-1:0];

endmodule

### rtl/core/sorted_timer_queue.sv
// ---------------------------------------------------------------------------
// sorted_timer_queue
// Up to NUM_TIMERS one-shot timers held in a deadline-ordered queue.
// The input channel (in_valid / in_ready / in_data) carries one command per
// transaction: start, cancel, tick, query or shutdown. The result channel
// (out_valid / out_ready / out_data) returns one or more result transactions
// per command; the final one has last set. A tick or shutdown returns one
// result per fired timer, in firing order, or a plain ok if none fires.
// Commands run one at a time on a sequencer around one shared 48-bit
// add/subtract unit and a queue memory (one read, one write port); in_ready
// is high only while idle. The queue walk sets the work per command: a start
// walks back from the tail past entries with a later or equal deadline, a
// cancel walks the whole queue, and a tick or shutdown pops fired timers
// from the head; a refused start, an idle cancel or an empty query walks
// nothing.
// Results sit in an output register, so a stalled receiver only holds the
// sequencer when it has another result to hand over.
// Reset (rst_n low, synchronous) empties the queue, sets time to zero and
// reopens the queue; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "sorted_timer_queue_assert.svh"

module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int NUM_TIMERS   = NUM_TIMERS_DEF,
  parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int SW = CW + 1;
  localparam logic [TIME_W-1:0] TO_MASK = {TIME_W{1'b1}} >> (TIME_W - TIMEOUT_BITS);

  // Sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DEC     = 4'd1;
  localparam logic [3:0] ST_S_ADD   = 4'd2;
  localparam logic [3:0] ST_INS_RD  = 4'd3;
  localparam logic [3:0] ST_INS_CMP = 4'd4;
  localparam logic [3:0] ST_C_RD    = 4'd5;
  localparam logic [3:0] ST_C_CMP   = 4'd6;
  localparam logic [3:0] ST_T_INC   = 4'd7;
  localparam logic [3:0] ST_T_RD    = 4'd8;
  localparam logic [3:0] ST_T_CMP   = 4'd9;
  localparam logic [3:0] ST_Q_RD    = 4'd10;
  localparam logic [3:0] ST_Q_CMP   = 4'd11;
  localparam logic [3:0] ST_EMIT    = 4'd12;

  typedef struct packed {
    logic [IW-1:0]     id;
    logic [TIME_W-1:0] dl;
  } ent_t;

  // Queue memory: entries in firing order, circular from hd_r
  ent_t mem [NUM_TIMERS];
  ent_t mem_rd_r;

  logic [3:0]            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         hd_r, hd_nxt;
  logic [NUM_TIMERS-1:0] flags_r, flags_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic                  closed_r, closed_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [3:0]            id_r, id_nxt;
  logic [TIME_W-1:0]     to_r, to_nxt;
  logic [TIME_W-1:0]     key_r, key_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic                  found_r, found_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [IW-1:0]         pend_id_r, pend_id_nxt;
  out_item_t             rs_r, rs_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [CW-1:0] rd_pos;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [CW-1:0] wr_pos;
  ent_t          wr_data;

  alu_req_t alu_req;
  alu_res_t alu_res;

  logic [8:0]        id_ext;
  logic [IW-1:0]     id_idx;
  logic              id_ok;
  logic              flag_hit;
  logic [8:0]        pend_ext;
  logic              out_free;
  logic              emit_v;
  out_item_t         emit_d;
  out_item_t         fin_res;
  logic              fire;
  logic [TIME_W-1:0] ttn;

  // Map a queue position onto a memory address
  function automatic logic [IW-1:0] phys(input logic [CW-1:0] pos,
                                         input logic [IW-1:0] hd);
    logic [SW-1:0] s;
    s = SW'(hd) + SW'(pos);
    if (s >= SW'(NUM_TIMERS)) begin
      s = s - SW'(NUM_TIMERS);
    end
    return s[IW-1:0];
  endfunction

  stq_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign id_ext   = 9'(id_r);
  assign id_idx   = id_ext[IW-1:0];
  assign id_ok    = (id_ext < 9'(NUM_TIMERS));
  assign flag_hit = flags_r[id_idx];
  assign pend_ext = 9'(pend_id_r);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign rd_addr  = phys(rd_pos, hd_r);

  // Final result of a tick or shutdown: last pending fire, or a plain ok
  always_comb begin
    fin_res = '0;
    fin_res.last = 1'b1;
    if (pend_v_r) begin
      fin_res.fired       = 1'b1;
      fin_res.fired_timer = pend_ext[3:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    hd_nxt      = hd_r;
    flags_nxt   = flags_r;
    now_nxt     = now_r;
    closed_nxt  = closed_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    to_nxt      = to_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    found_nxt   = found_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    rs_nxt      = rs_r;
    rd_pos      = '0;
    wr_en       = 1'b0;
    wr_pos      = '0;
    wr_data     = '0;
    alu_req     = '0;
    emit_v      = 1'b0;
    emit_d      = '0;
    fire        = 1'b0;
    ttn         = '0;

    unique case (state_r)
      ST_IDLE: begin
        // Capture the command
        if (in_valid) begin
          op_nxt    = in_data.operation;
          id_nxt    = in_data.timer_id;
          to_nxt    = TIME_W'(in_data.timeout_ticks) & TO_MASK;
          state_nxt = ST_DEC;
        end
      end

      ST_DEC: begin
        pend_v_nxt = 1'b0;
        rs_nxt     = '0;
        rs_nxt.last = 1'b1;
        unique case (op_r)
          OP_START: begin
            priority if (closed_r) begin
              rs_nxt.status = STS_CLOSED;
              state_nxt     = ST_EMIT;
            end else if (!id_ok) begin
              state_nxt = ST_EMIT;
            end else if (flag_hit) begin
              rs_nxt.status = STS_RUNNING;
              state_nxt     = ST_EMIT;
            end else begin
              state_nxt = ST_S_ADD;
            end
          end
          OP_CANCEL: begin
            if (id_ok && flag_hit) begin
              pos_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = ST_C_RD;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
          OP_TICK: begin
            state_nxt = ST_T_INC;
          end
          OP_QUERY: begin
            if (cnt_r == '0) begin
              rs_nxt.status = STS_EMPTY;
              state_nxt     = ST_EMIT;
            end else begin
              state_nxt = ST_Q_RD;
            end
          end
          OP_SHUTDOWN: begin
            closed_nxt = 1'b1;
            state_nxt  = ST_T_RD;
          end
          default: begin
            state_nxt = ST_EMIT;
          end
        endcase
      end

      ST_S_ADD: begin
        // Deadline = now + timeout, saturated
        alu_req.a   = now_r;
        alu_req.b   = to_r;
        alu_req.sub = 1'b0;
        key_nxt     = alu_res.carry ? TIME_MAX : alu_res.sum;
        pos_nxt     = cnt_r;
        state_nxt   = ST_INS_RD;
      end

      ST_INS_RD: begin
        // Reached the head: place the new timer first
        if (pos_r == '0) begin
          wr_en      = 1'b1;
          wr_pos     = '0;
          wr_data.id = id_idx;
          wr_data.dl = key_r;
          cnt_nxt    = cnt_r + CW'(1);
          flags_nxt[id_idx] = 1'b1;
          state_nxt  = ST_EMIT;
        end else begin
          rd_pos    = pos_r - CW'(1);
          state_nxt = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        // Stop behind an earlier deadline, else shift the entry back one
        alu_req.a   = mem_rd_r.dl;
        alu_req.b   = key_r;
        alu_req.sub = 1'b1;
        wr_en       = 1'b1;
        wr_pos      = pos_r;
        if (!alu_res.carry) begin
          wr_data.id = id_idx;
          wr_data.dl = key_r;
          cnt_nxt    = cnt_r + CW'(1);
          flags_nxt[id_idx] = 1'b1;
          state_nxt  = ST_EMIT;
        end else begin
          wr_data   = mem_rd_r;
          pos_nxt   = pos_r - CW'(1);
          state_nxt = ST_INS_RD;
        end
      end

      ST_C_RD: begin
        rd_pos    = pos_r;
        state_nxt = ST_C_CMP;
      end

      ST_C_CMP: begin
        // Shift entries after the cancelled one forward
        if (found_r) begin
          wr_en   = 1'b1;
          wr_pos  = pos_r - CW'(1);
          wr_data = mem_rd_r;
        end else if (mem_rd_r.id == id_idx) begin
          found_nxt = 1'b1;
        end
        if (pos_r == cnt_r - CW'(1)) begin
          cnt_nxt   = cnt_r - CW'(1);
          flags_nxt[id_idx] = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = ST_C_RD;
        end
      end

      ST_T_INC: begin
        // Advance time, saturating
        alu_req.a   = now_r;
        alu_req.b   = TIME_W'(1);
        alu_req.sub = 1'b0;
        now_nxt     = alu_res.carry ? TIME_MAX : alu_res.sum;
        state_nxt   = ST_T_RD;
      end

      ST_T_RD: begin
        rd_pos = '0;
        if (cnt_r == '0) begin
          rs_nxt    = fin_res;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_T_CMP;
        end
      end

      ST_T_CMP: begin
        // Pop the head if it expired (any head on shutdown); hold one fire back to mark the last
        rd_pos      = '0;
        alu_req.a   = mem_rd_r.dl;
        alu_req.b   = now_r;
        alu_req.sub = 1'b1;
        fire        = (op_r == OP_SHUTDOWN) || !alu_res.carry;
        if (fire) begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              emit_v             = 1'b1;
              emit_d.fired       = 1'b1;
              emit_d.fired_timer = pend_ext[3:0];
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = mem_rd_r.id;
            hd_nxt      = phys(CW'(1), hd_r);
            cnt_nxt     = cnt_r - CW'(1);
            flags_nxt[mem_rd_r.id] = 1'b0;
            state_nxt   = ST_T_RD;
          end
        end else begin
          rs_nxt    = fin_res;
          state_nxt = ST_EMIT;
        end
      end

      ST_Q_RD: begin
        rd_pos    = '0;
        state_nxt = ST_Q_CMP;
      end

      ST_Q_CMP: begin
        // Ticks left = head deadline - now, floored at zero, saturated
        alu_req.a   = mem_rd_r.dl;
        alu_req.b   = now_r;
        alu_req.sub = 1'b1;
        ttn         = alu_res.carry ? alu_res.sum : '0;
        if (ttn > TO_MASK) begin
          ttn = TO_MASK;
        end
        rs_nxt.time_to_next = ttn[31:0];
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          emit_v    = 1'b1;
          emit_d    = rs_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_v) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_d;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Queue memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[phys(wr_pos, hd_r)] <= wr_data;
    end
    mem_rd_r <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      hd_r        <= '0;
      flags_r     <= '0;
      now_r       <= '0;
      closed_r    <= 1'b0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hd_r        <= hd_nxt;
      flags_r     <= flags_nxt;
      now_r       <= now_nxt;
      closed_r    <= closed_nxt;
      found_r     <= found_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    to_r       <= to_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    pend_id_r  <= pend_id_nxt;
    rs_r       <= rs_nxt;
    out_data_r <= out_data_nxt;
  end

  // Assertions
  `STQ_ASSERT(a_cnt_bound, cnt_r <= CW'(NUM_TIMERS), "queue count above capacity")
  `STQ_ASSERT(a_flags_cnt, $countones(flags_r) == int'(cnt_r), "running flags disagree with count")
  `STQ_ASSERT_NEXT(a_closed_hold, closed_r, closed_r, "shutdown flag cleared outside reset")
  `STQ_ASSERT_NEXT(a_accept_dec, in_valid && in_ready, state_r == ST_DEC, "accepted command not decoded")

endmodule

### bench/tb_sorted_timer_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sorted_timer_queue
// Self-checking bench for the deadline-ordered timer queue. Commands run
// through a backlog-fed driver. A cycle-free predictor keeps its own queue,
// clock and timer table, and it queues the result transactions that each
// accepted command must produce. The monitor checks every result against
// the oldest one still owed. Phases vary sender gaps and receiver stalls,
// and include one long receiver hold-off. Shutdown closes the queue for
// good, so it runs only in the final phase.
// ---------------------------------------------------------------------------
module tb_sorted_timer_queue;
  import stq_pkg::*;

  localparam int          CLK_PERIOD     = 8;
  localparam int          QUIET_LIMIT    = 4000;
  localparam int          RX_HOLD_CYCLES = 200;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          PHASE_ITEMS    = 17;
  localparam int          REPORT_MAX     = 10;
  localparam logic [47:0] TTN_MAX        = 48'h0000_FFFF_FFFF;

  // Operation codes the block does not define
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_e;

  typedef struct {
    in_item_t cmd;
    phase_e   phase;
    bit       hold_rx;
    bit       wait_drain;
  } pending_cmd_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic   tx_hold = 1'b0;
  phase_e cur_phase = PH_FREE;
  int     rx_hold_left = 0;
  int     owed_results = 0;
  int     mismatch_count = 0;

  pending_cmd_t cmd_backlog[$];
  out_item_t    expected_results[$];

  // Predictor state
  logic [47:0] timer_deadline [16];
  logic [3:0]  firing_order[$];
  logic [15:0] timer_armed = '0;
  logic [47:0] now_ticks = '0;
  logic        queue_closed = 1'b0;

  phase_e fill_phase = PH_FREE;

  sorted_timer_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Queue one expected result transaction, last cleared
  function automatic void post_result(input logic [1:0] st, input logic fired,
                                      input logic [3:0] who, input logic [31:0] ttn);
    out_item_t r;
    r.status       = st;
    r.fired        = fired;
    r.fired_timer  = who;
    r.time_to_next = ttn;
    r.last         = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Pop and report every head timer that is due (all of them on shutdown)
  function automatic void fire_due(input bit fire_all);
    logic [3:0] who;
    while (firing_order.size() != 0 &&
           (fire_all || timer_deadline[firing_order[0]] < now_ticks)) begin
      who = firing_order.pop_front();
      timer_armed[who] = 1'b0;
      post_result(STS_OK, 1'b1, who, '0);
    end
  endfunction

  // Advance the predicted queue by one command and queue its results
  function automatic void predict_command(input in_item_t cmd);
    int          first;
    int          pos;
    logic [48:0] sum;
    logic [47:0] due;
    logic [47:0] gap;
    out_item_t   tail;
    first = expected_results.size();
    case (cmd.operation)
      OP_START: begin
        if (queue_closed) begin
          post_result(STS_CLOSED, 1'b0, '0, '0);
        end else if (timer_armed[cmd.timer_id]) begin
          post_result(STS_RUNNING, 1'b0, '0, '0);
        end else begin
          sum = {1'b0, now_ticks} + {17'd0, cmd.timeout_ticks};
          due = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[47:0];
          timer_deadline[cmd.timer_id] = due;
          // land after every strictly earlier deadline
          pos = 0;
          while (pos < firing_order.size() && timer_deadline[firing_order[pos]] < due)
            pos++;
          firing_order.insert(pos, cmd.timer_id);
          timer_armed[cmd.timer_id] = 1'b1;
          post_result(STS_OK, 1'b0, '0, '0);
        end
      end
      OP_CANCEL: begin
        if (timer_armed[cmd.timer_id]) begin
          for (int i = 0; i < firing_order.size(); i++) begin
            if (firing_order[i] == cmd.timer_id) begin
              firing_order.delete(i);
              break;
            end
          end
          timer_armed[cmd.timer_id] = 1'b0;
        end
        post_result(STS_OK, 1'b0, '0, '0);
      end
      OP_TICK: begin
        if (now_ticks != TIME_MAX) now_ticks = now_ticks + 48'd1;
        fire_due(1'b0);
      end
      OP_QUERY: begin
        if (firing_order.size() == 0) begin
          post_result(STS_EMPTY, 1'b0, '0, '0);
        end else begin
          due = timer_deadline[firing_order[0]];
          gap = (due > now_ticks) ? due - now_ticks : '0;
          if (gap > TTN_MAX) gap = TTN_MAX;
          post_result(STS_OK, 1'b0, '0, gap[31:0]);
        end
      end
      OP_SHUTDOWN: begin
        queue_closed = 1'b1;
        fire_due(1'b1);
      end
      default: post_result(STS_OK, 1'b0, '0, '0);
    endcase
    // tick or shutdown that fired nothing still answers once
    if (expected_results.size() == first) post_result(STS_OK, 1'b0, '0, '0);
    tail = expected_results.pop_back();
    tail.last = 1'b1;
    expected_results.push_back(tail);
  endfunction

  function automatic void report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  function automatic void add_cmd(input logic [2:0] op, input logic [3:0] id,
                                  input logic [31:0] timeout, input bit hold_rx = 1'b0,
                                  input bit wait_drain = 1'b0);
    pending_cmd_t p;
    p.cmd.operation     = op;
    p.cmd.timer_id      = id;
    p.cmd.timeout_ticks = timeout;
    p.phase             = fill_phase;
    p.hold_rx           = hold_rx;
    p.wait_drain        = wait_drain;
    cmd_backlog.push_back(p);
  endfunction

  // Random command: mostly starts and ticks with short timeouts
  function automatic void add_random_cmd(input bit hold_rx = 1'b0,
                                         input bit wait_drain = 1'b0);
    int          pick;
    logic [2:0]  op;
    logic [31:0] timeout;
    pick = $urandom_range(99);
    if (pick < 40) op = OP_START;
    else if (pick < 70) op = OP_TICK;
    else if (pick < 82) op = OP_CANCEL;
    else if (pick < 94) op = OP_QUERY;
    else begin
      case ($urandom_range(2))
        0: op = OP_SPARE_A;
        1: op = OP_SPARE_B;
        default: op = OP_SPARE_C;
      endcase
    end
    timeout = ($urandom_range(99) < 85) ? 32'($urandom_range(12)) : 32'($urandom);
    add_cmd(op, 4'($urandom_range(15)), timeout, hold_rx, wait_drain);
  endfunction

  // Drive commands from the backlog; hold the payload until accepted
  always @(posedge clk) begin : driver
    pending_cmd_t nxt;
    int           gap_pct;
    bit           blocked;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      tx_hold   <= 1'b0;
      cur_phase <= PH_FREE;
    end else if (!in_valid || in_ready) begin
      if (cmd_backlog.size() != 0) begin
        nxt     = cmd_backlog[0];
        gap_pct = (nxt.phase == PH_SEND_IDLE) ? 65 : (nxt.phase == PH_BOTH) ? 30 : 0;
        // a draining command waits until every owed result has come back
        blocked = nxt.wait_drain && (in_valid || owed_results != 0);
        if (!blocked && $urandom_range(99) >= gap_pct) begin
          in_valid  <= 1'b1;
          in_data   <= nxt.cmd;
          tx_hold   <= nxt.hold_rx;
          cur_phase <= nxt.phase;
          void'(cmd_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per phase, long hold-off on a marked command
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      rx_hold_left <= 0;
    end else if (in_valid && in_ready && tx_hold) begin
      out_ready    <= 1'b0;
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ready <= $urandom_range(99) >=
                   ((cur_phase == PH_RECV_STALL) ? 65 : (cur_phase == PH_BOTH) ? 30 : 0);
    end
  end

  // Predict on command transactions, check result transactions, watchdog
  always @(posedge clk) begin : monitor
    out_item_t want;
    int        quiet_cycles;
    if (!rst_n) begin
      owed_results <= 0;
      quiet_cycles = 0;
    end else begin
      if (in_valid && in_ready) predict_command(in_data);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result sts=%0d fired=%0b id=%0d ttn=%0d last=%0b",
                                    out_data.status, out_data.fired, out_data.fired_timer,
                                    out_data.time_to_next, out_data.last));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.fired !== want.fired ||
              out_data.fired_timer !== want.fired_timer ||
              out_data.time_to_next !== want.time_to_next || out_data.last !== want.last)
            report_mismatch($sformatf(
              "sts %0d/%0d fired %0b/%0b id %0d/%0d ttn %0d/%0d last %0b/%0b (exp/got)",
              want.status, out_data.status, want.fired, out_data.fired,
              want.fired_timer, out_data.fired_timer, want.time_to_next,
              out_data.time_to_next, want.last, out_data.last));
        end
      end
      owed_results <= expected_results.size();
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    // Directed: empty queue, extremes, refusals, equal deadlines, spare codes
    fill_phase = PH_FREE;
    add_cmd(OP_QUERY, 4'd0, 32'd0);
    add_cmd(OP_TICK, 4'd0, 32'd0);
    add_cmd(OP_START, 4'd0, 32'd0);
    add_cmd(OP_START, 4'd15, 32'hFFFF_FFFF);
    add_cmd(OP_START, 4'd0, 32'd9);
    add_cmd(OP_QUERY, 4'd0, 32'd0);
    add_cmd(OP_START, 4'd3, 32'd2);
    add_cmd(OP_START, 4'd4, 32'd2);
    add_cmd(OP_TICK, 4'd0, 32'd0);
    add_cmd(OP_CANCEL, 4'd7, 32'd0);
    add_cmd(OP_START, 4'd7, 32'd5);
    add_cmd(OP_CANCEL, 4'd7, 32'd0);
    add_cmd(OP_TICK, 4'd0, 32'd0);
    add_cmd(OP_TICK, 4'd0, 32'd0);
    add_cmd(OP_QUERY, 4'd0, 32'd0);
    add_cmd(OP_SPARE_A, 4'd10, 32'hA5A5_5A5A);
    add_cmd(OP_SPARE_B, 4'd5, 32'h5A5A_A5A5);
    add_cmd(OP_SPARE_C, 4'd15, 32'hFFFF_FFFF);
    add_cmd(OP_CANCEL, 4'd15, 32'd0);
    add_cmd(OP_QUERY, 4'd0, 32'd0);

    // Random phases; the first opens with a long receiver hold-off
    fill_phase = PH_FREE;
    add_random_cmd(1'b1, 1'b0);
    repeat (PHASE_ITEMS - 1) add_random_cmd();
    fill_phase = PH_SEND_IDLE;
    add_random_cmd(1'b0, 1'b1);
    repeat (PHASE_ITEMS - 1) add_random_cmd();
    fill_phase = PH_RECV_STALL;
    repeat (PHASE_ITEMS) add_random_cmd();
    fill_phase = PH_BOTH;
    repeat (PHASE_ITEMS) add_random_cmd();

    // Final: fill every slot, then shut down and poke the closed queue
    fill_phase = PH_RECV_STALL;
    for (int id = 0; id < 16; id++)
      add_cmd(OP_START, 4'(id), 32'($urandom_range(2000, 100)), 1'b0, id == 0);
    add_cmd(OP_SHUTDOWN, 4'd0, 32'd0);
    add_cmd(OP_START, 4'd6, 32'd3);
    add_cmd(OP_SHUTDOWN, 4'd0, 32'd0);
    add_cmd(OP_TICK, 4'd0, 32'd0);
    add_cmd(OP_QUERY, 4'd0, 32'd0);
    add_cmd(OP_CANCEL, 4'd6, 32'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every command is taken and every result is back
    while (cmd_backlog.size() != 0 || in_valid || owed_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/stq_pkg.sv
rtl/core/stq_alu.sv
rtl/core/sorted_timer_queue.sv
bench/tb_sorted_timer_queue.sv
